// File: hw/rtl/assert_macros.svh
// assertion helpers, clocked on clock; ASSERT_CLK is quiet while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: hw/rtl/bbe_pkg.sv
package bbe_pkg;

   // field widths
   localparam int KIND_W = 1;
   localparam int POS_W  = 8;
   localparam int GRAY_W = 8;
   localparam int DIM_W  = 9;
   localparam int RAD_W  = 4;

   // csr port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_RADIUS_X     = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_RADIUS_Y     = 2'd3;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 9'd256;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 9'd256;
   localparam logic [RAD_W-1:0] RADIUS_X_RST     = 4'd1;
   localparam logic [RAD_W-1:0] RADIUS_Y_RST     = 4'd1;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
   localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

   // parameter defaults
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int MAX_RADIUS_DEF = 15;

endpackage

// File: hw/rtl/bbe_if.sv
interface bbe_req_if;
   logic                          valid;
   logic                          ready;
   logic [bbe_pkg::KIND_W-1:0]    kind;
   logic [bbe_pkg::POS_W-1:0]     pos_x;
   logic [bbe_pkg::POS_W-1:0]     pos_y;
   logic [bbe_pkg::GRAY_W-1:0]    gray_in;

   modport source (output valid, kind, pos_x, pos_y, gray_in, input ready);
   modport sink   (input valid, kind, pos_x, pos_y, gray_in, output ready);
endinterface

interface bbe_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bbe_pkg::GRAY_W-1:0]    gray_out;
   logic                          pos_error;

   modport source (output valid, gray_out, pos_error, input ready);
   modport sink   (input valid, gray_out, pos_error, output ready);
endinterface

// File: hw/rtl/box_blur_edge_normalized_top.sv
// Edge-normalized box blur over one stored 8-bit frame. A load beat writes one pixel;
// loads outside the frame are dropped. A query beat returns the rounded mean of the
// window around (pos_x,pos_y), counting only in-frame pixels, or 0 with pos_error set
// when the position lies outside the frame. The frame memory has one read port, so a
// query reads its N in-frame window pixels one per cycle and then runs an 8-step
// shift-subtract divide; no new beat is taken until the query's result is in the
// output register. The output register lets a load be taken while a result still
// waits. Pixels must be loaded before a query window covers them; there is no
// clearing pass after reset.
`include "assert_macros.svh"

module box_blur_edge_normalized_top #(
   parameter int MAX_WIDTH  = bbe_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bbe_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_RADIUS = bbe_pkg::MAX_RADIUS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   bbe_req_if.sink                           req_ch,
   bbe_rsp_if.source                         rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bbe_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [bbe_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [bbe_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   localparam int GW       = bbe_pkg::GRAY_W;
   localparam int DW       = bbe_pkg::DIM_W;
   localparam int RW       = bbe_pkg::RAD_W;
   localparam int CW       = bbe_pkg::POS_W + 1;
   localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DIM_CAP  = (1 << DW) - 1;
   localparam int WCAP     = (MAX_WIDTH < DIM_CAP) ? MAX_WIDTH : DIM_CAP;
   localparam int HCAP     = (MAX_HEIGHT < DIM_CAP) ? MAX_HEIGHT : DIM_CAP;
   localparam int RAD_CAP  = (1 << RW) - 1;
   localparam int RMAX     = (MAX_RADIUS < RAD_CAP) ? MAX_RADIUS : RAD_CAP;
   localparam int SIDE_MAX = 2 * RMAX + 1;
   localparam int SIDE_W   = $clog2(SIDE_MAX + 1);
   localparam int CNT_MAX  = SIDE_MAX * SIDE_MAX;
   localparam int CNT_W    = $clog2(CNT_MAX + 1);
   localparam int SUM_W    = $clog2(CNT_MAX * ((1 << GW) - 1) + 1);
   localparam int NUM_W    = SUM_W + 2;
   localparam int STEP_W   = $clog2(GW);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_SUM   = 3'd2;
   localparam logic [2:0] ST_TAIL  = 3'd3;
   localparam logic [2:0] ST_PREP  = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   // configuration registers
   logic [DW-1:0] frame_width_ff, frame_height_ff;
   logic [RW-1:0] radius_x_ff, radius_y_ff;

   // sequencer
   logic [2:0]        state_ff, state_in;
   logic [CW-1:0]     x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic [CW-1:0]     i_ff, i_in, j_ff, j_in;
   logic [AW-1:0]     addr_ff, addr_in, row_ff, row_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [NUM_W-1:0]  num_ff, num_in, dsh_ff, dsh_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [GW-1:0]     quot_ff, quot_in;
   logic              err_ff, err_in;
   logic              rd_vld_ff;
   logic [GW-1:0]     rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [GW-1:0]     rsp_gray_ff, rsp_gray_in;
   logic              rsp_err_ff, rsp_err_in;

   // frame memory
   logic [GW-1:0] frame_mem [DEPTH];
   logic          mem_we;
   logic [AW-1:0] wr_addr;

   // decode of the incoming beat
   logic [DW-1:0] w_eff, h_eff;
   logic [RW-1:0] rx_eff, ry_eff;
   logic [CW-1:0] px, py, lo_x, lo_y, hi_x, hi_y;
   logic          in_frame, req_fire, csr_write;
   logic [SIDE_W-1:0] side_x, side_y;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      case (paddr[bbe_pkg::CSR_ADDR_W-1:2])
         bbe_pkg::REG_FRAME_WIDTH:  prdata = bbe_pkg::CSR_DATA_W'(frame_width_ff);
         bbe_pkg::REG_FRAME_HEIGHT: prdata = bbe_pkg::CSR_DATA_W'(frame_height_ff);
         bbe_pkg::REG_RADIUS_X:     prdata = bbe_pkg::CSR_DATA_W'(radius_x_ff);
         bbe_pkg::REG_RADIUS_Y:     prdata = bbe_pkg::CSR_DATA_W'(radius_y_ff);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bbe_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= bbe_pkg::FRAME_HEIGHT_RST;
         radius_x_ff     <= bbe_pkg::RADIUS_X_RST;
         radius_y_ff     <= bbe_pkg::RADIUS_Y_RST;
      end else if (csr_write) begin
         case (paddr[bbe_pkg::CSR_ADDR_W-1:2])
            bbe_pkg::REG_FRAME_WIDTH:  frame_width_ff  <= pwdata[DW-1:0];
            bbe_pkg::REG_FRAME_HEIGHT: frame_height_ff <= pwdata[DW-1:0];
            bbe_pkg::REG_RADIUS_X:     radius_x_ff     <= pwdata[RW-1:0];
            bbe_pkg::REG_RADIUS_Y:     radius_y_ff     <= pwdata[RW-1:0];
            default: ;
         endcase
      end
   end

   // clamped dimensions and radii
   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = DW'(1);
      end else if (frame_width_ff > DW'(WCAP)) begin
         w_eff = DW'(WCAP);
      end else begin
         w_eff = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         h_eff = DW'(1);
      end else if (frame_height_ff > DW'(HCAP)) begin
         h_eff = DW'(HCAP);
      end else begin
         h_eff = frame_height_ff;
      end
      rx_eff = (radius_x_ff > RW'(RMAX)) ? RW'(RMAX) : radius_x_ff;
      ry_eff = (radius_y_ff > RW'(RMAX)) ? RW'(RMAX) : radius_y_ff;

      px       = CW'(req_ch.pos_x);
      py       = CW'(req_ch.pos_y);
      in_frame = (px < CW'(w_eff)) && (py < CW'(h_eff));

      // window clipped to the frame
      lo_x = (px >= CW'(rx_eff)) ? px - CW'(rx_eff) : '0;
      lo_y = (py >= CW'(ry_eff)) ? py - CW'(ry_eff) : '0;
      hi_x = px + CW'(rx_eff);
      hi_y = py + CW'(ry_eff);
      if (hi_x > CW'(w_eff - DW'(1))) hi_x = CW'(w_eff - DW'(1));
      if (hi_y > CW'(h_eff - DW'(1))) hi_y = CW'(h_eff - DW'(1));
   end

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign mem_we       = req_fire && (req_ch.kind == bbe_pkg::KIND_LOAD) && in_frame;
   assign wr_addr      = AW'(AW'(req_ch.pos_y) * AW'(MAX_WIDTH)) + AW'(req_ch.pos_x);

   assign side_x = SIDE_W'(x1_ff - x0_ff + CW'(1));
   assign side_y = SIDE_W'(y1_ff - y0_ff + CW'(1));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[wr_addr] <= req_ch.gray_in;
      end
      rd_data_ff <= frame_mem[addr_ff];
   end

   always_comb begin
      state_in     = state_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      addr_in      = addr_ff;
      row_in       = row_ff;
      count_in     = count_ff;
      num_in       = num_ff;
      dsh_in       = dsh_ff;
      step_in      = step_ff;
      quot_in      = quot_ff;
      err_in       = err_ff;
      sum_in       = sum_ff + (rd_vld_ff ? SUM_W'(rd_data_ff) : '0);
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_gray_in  = rsp_gray_ff;
      rsp_err_in   = rsp_err_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_ch.kind == bbe_pkg::KIND_QUERY)) begin
               x0_in = lo_x;
               x1_in = hi_x;
               y0_in = lo_y;
               y1_in = hi_y;
               if (in_frame) begin
                  err_in   = 1'b0;
                  state_in = ST_SETUP;
               end else begin
                  err_in   = 1'b1;
                  quot_in  = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_SETUP: begin
            count_in = CNT_W'(CNT_W'(side_x) * CNT_W'(side_y));
            addr_in  = AW'(AW'(y0_ff) * AW'(MAX_WIDTH)) + AW'(x0_ff);
            row_in   = AW'(AW'(y0_ff) * AW'(MAX_WIDTH)) + AW'(x0_ff);
            i_in     = x0_ff;
            j_in     = y0_ff;
            sum_in   = '0;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // one pixel read per cycle, added to the sum in the following cycle
            if (i_ff == x1_ff) begin
               if (j_ff == y1_ff) begin
                  state_in = ST_TAIL;
               end else begin
                  i_in    = x0_ff;
                  j_in    = j_ff + CW'(1);
                  row_in  = row_ff + AW'(MAX_WIDTH);
                  addr_in = row_ff + AW'(MAX_WIDTH);
               end
            end else begin
               i_in    = i_ff + CW'(1);
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_TAIL: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            // numerator 2*sum+count, divisor 2*count aligned to the top quotient bit
            num_in   = NUM_W'({sum_ff, 1'b0}) + NUM_W'(count_ff);
            dsh_in   = NUM_W'(count_ff) << GW;
            step_in  = STEP_W'(GW - 1);
            quot_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (num_ff >= dsh_ff) begin
               num_in  = num_ff - dsh_ff;
               quot_in = {quot_ff[GW-2:0], 1'b1};
            end else begin
               quot_in = {quot_ff[GW-2:0], 1'b0};
            end
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_gray_in  = quot_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= (state_ff == ST_SUM);
         rsp_valid_ff <= rsp_valid_in;
      end
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y0_ff       <= y0_in;
      y1_ff       <= y1_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      addr_ff     <= addr_in;
      row_ff      <= row_in;
      count_ff    <= count_in;
      sum_ff      <= sum_in;
      num_ff      <= num_in;
      dsh_ff      <= dsh_in;
      step_ff     <= step_in;
      quot_ff     <= quot_in;
      err_ff      <= err_in;
      rsp_gray_ff <= rsp_gray_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.gray_out  = rsp_gray_ff;
   assign rsp_ch.pos_error = rsp_err_ff;

   `ASSERT_CLK(a_err_gray_zero, rsp_valid_ff && rsp_err_ff |-> rsp_gray_ff == '0,
      "error beat carries a non-zero gray level")
   `ASSERT_CLK(a_scan_in_window, state_ff == ST_SUM |-> i_ff <= x1_ff && j_ff <= y1_ff,
      "window scan ran past its bounds")
   `ASSERT_CLK(a_count_nonzero, state_ff == ST_DIV |-> count_ff != '0,
      "divide started with an empty window")
   `ASSERT_CLK(a_tail_after_read, state_ff == ST_TAIL |-> rd_vld_ff,
      "last window pixel not read before the tail")
   `ASSERT_CLK(a_done_delivers,
      state_ff == ST_DONE && (!rsp_valid_ff || rsp_ch.ready) |=>
         rsp_valid_ff && state_ff == ST_IDLE,
      "finished result not moved to the output register")

endmodule
